### src/v2p_pkg.sv
// Shared types, constants and the arctangent table for the vector-to-polar pipeline.
`default_nettype none

package v2p_pkg;

  // angles inside the pipeline are in units of 2^-ZQ degree
  localparam int ZQ           = 24;
  localparam int CORDIC_STEPS = 24;
  // CORDIC x/y datapath and angle accumulator widths
  localparam int CW           = 64;
  localparam int ZW           = 34;

  localparam logic signed [ZW-1:0] DEG90_Q  = ZW'(64'd90 << ZQ);
  localparam logic signed [ZW-1:0] DEG180_Q = ZW'(64'd180 << ZQ);
  localparam logic signed [ZW-1:0] DEG360_Q = ZW'(64'd360 << ZQ);

  // one radian in 2^-24 degree
  localparam logic [63:0] RAD_IN_DEG_Q = 64'd961263669;

  typedef struct packed {
    logic ax_zero;
    logic ay_zero;
    logic x_neg;
    logic y_neg;
  } v2p_flags_t;

  // atan(2^-i) in 2^-24 degree, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(64'd754974720);
      1:  v = ZW'(64'd445687602);
      2:  v = ZW'(64'd235489088);
      3:  v = ZW'(64'd119537938);
      4:  v = ZW'(64'd60000934);
      5:  v = ZW'(64'd30029717);
      6:  v = ZW'(64'd15018523);
      7:  v = ZW'(64'd7509720);
      8:  v = ZW'(64'd3754917);
      9:  v = ZW'(64'd1877466);
      10: v = ZW'(64'd938734);
      11: v = ZW'(64'd469367);
      default: v = ZW'((RAD_IN_DEG_Q + (64'd1 << (i - 1))) >> i);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### src/v2p_front.sv
// Input stages: absolute values, axis/sign flags, squares and their sum.
`default_nettype none

module v2p_front
  import v2p_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       valid_i,
  input  wire logic signed [COORD_BITS-1:0] x_i,
  input  wire logic signed [COORD_BITS-1:0] y_i,
  output logic                            valid_o,
  output v2p_flags_t                      flags_o,
  output logic [COORD_BITS-1:0]           ax_o,
  output logic [COORD_BITS-1:0]           ay_o,
  output logic [2*COORD_BITS-1:0]         n_o
);

  localparam int CB = COORD_BITS;

  logic                      va_r, vb_r;
  v2p_flags_t                fa_r, fb_r, fa_nxt;
  logic [CB-1:0]             axa_r, aya_r, axb_r, ayb_r, ax_nxt, ay_nxt;
  logic signed [2*CB-1:0]    sqx_nxt, sqy_nxt;
  logic [2*CB-1:0]           sqx_r, sqy_r, n_r, n_nxt;

  // most negative input maps to 2^(CB-1) as an unsigned magnitude
  assign ax_nxt  = x_i[CB-1] ? $unsigned(-x_i) : $unsigned(x_i);
  assign ay_nxt  = y_i[CB-1] ? $unsigned(-y_i) : $unsigned(y_i);
  assign sqx_nxt = x_i * x_i;
  assign sqy_nxt = y_i * y_i;
  assign n_nxt   = sqx_r + sqy_r;

  always_comb begin
    fa_nxt.ax_zero = (x_i == '0);
    fa_nxt.ay_zero = (y_i == '0);
    fa_nxt.x_neg   = x_i[CB-1];
    fa_nxt.y_neg   = y_i[CB-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= valid_i;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    fa_r  <= fa_nxt;
    axa_r <= ax_nxt;
    aya_r <= ay_nxt;
    sqx_r <= $unsigned(sqx_nxt);
    sqy_r <= $unsigned(sqy_nxt);
    fb_r  <= fa_r;
    axb_r <= axa_r;
    ayb_r <= aya_r;
    n_r   <= n_nxt;
  end

  assign valid_o = vb_r;
  assign flags_o = fb_r;
  assign ax_o    = axb_r;
  assign ay_o    = ayb_r;
  assign n_o     = n_r;

endmodule

`default_nettype wire

### src/v2p_cordic_step.sv
// One vectoring CORDIC micro-rotation stage; also carries valid and flags.
`default_nettype none

module v2p_cordic_step
  import v2p_pkg::*;
#(
  parameter int STEP   = 0,
  parameter bit ACTIVE = 1'b1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 valid_i,
  input  wire v2p_flags_t           flags_i,
  input  wire logic signed [CW-1:0] cx_i,
  input  wire logic signed [CW-1:0] cy_i,
  input  wire logic signed [ZW-1:0] z_i,
  output logic                      valid_o,
  output v2p_flags_t                flags_o,
  output logic signed [CW-1:0]      cx_o,
  output logic signed [CW-1:0]      cy_o,
  output logic signed [ZW-1:0]      z_o
);

  localparam logic signed [ZW-1:0] ATAN = atan_q(STEP);

  logic                 valid_r;
  v2p_flags_t           flags_r;
  logic signed [CW-1:0] cx_r, cy_r, cx_nxt, cy_nxt, sx, sy;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 pos;

  assign sx  = cx_i >>> STEP;
  assign sy  = cy_i >>> STEP;
  assign pos = !cy_i[CW-1] && (cy_i != '0);

  always_comb begin
    if (!ACTIVE) begin
      cx_nxt = cx_i;
      cy_nxt = cy_i;
      z_nxt  = z_i;
    end else if (pos) begin
      cx_nxt = cx_i + sy;
      cy_nxt = cy_i - sx;
      z_nxt  = z_i + ATAN;
    end else begin
      cx_nxt = cx_i - sy;
      cy_nxt = cy_i + sx;
      z_nxt  = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    flags_r <= flags_i;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    z_r     <= z_nxt;
  end

  assign valid_o = valid_r;
  assign flags_o = flags_r;
  assign cx_o    = cx_r;
  assign cy_o    = cy_r;
  assign z_o     = z_r;

endmodule

`default_nettype wire

### src/v2p_sqrt_step.sv
// One result bit of the digit-by-digit integer square root.
`default_nettype none

module v2p_sqrt_step #(
  parameter int COORD_BITS = 16,
  parameter bit ACTIVE     = 1'b1
) (
  input  wire logic                    clk,
  input  wire logic [2*COORD_BITS-1:0] n_i,
  input  wire logic [COORD_BITS+1:0]   rem_i,
  input  wire logic [COORD_BITS-1:0]   q_i,
  output logic [2*COORD_BITS-1:0]      n_o,
  output logic [COORD_BITS+1:0]        rem_o,
  output logic [COORD_BITS-1:0]        q_o
);

  localparam int CB = COORD_BITS;

  logic [2*CB-1:0] n_r, n_nxt;
  logic [CB+1:0]   rem_r, rem_nxt, rs, trial;
  logic [CB-1:0]   q_r, q_nxt;
  logic            ge;

  // bring down the next two radicand bits; trial subtrahend is 4q+1
  assign rs    = {rem_i[CB-1:0], n_i[2*CB-1 -: 2]};
  assign trial = {q_i, 2'b01};
  assign ge    = (rs >= trial);

  always_comb begin
    if (ACTIVE) begin
      n_nxt   = n_i << 2;
      rem_nxt = ge ? rs - trial : rs;
      q_nxt   = {q_i[CB-2:0], ge};
    end else begin
      n_nxt   = n_i;
      rem_nxt = rem_i;
      q_nxt   = q_i;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign n_o   = n_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule

`default_nettype wire

### src/v2p_back.sv
// Output stages: clamp, quadrant mapping, angle rounding with wrap, magnitude rounding.
`default_nettype none

module v2p_back
  import v2p_pkg::*;
#(
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   valid_i,
  input  wire v2p_flags_t             flags_i,
  input  wire logic signed [ZW-1:0]   z_i,
  input  wire logic [COORD_BITS+1:0]  rem_i,
  input  wire logic [COORD_BITS-1:0]  q_i,
  output logic                        valid_o,
  output logic [15:0]                 angle_o,
  output logic [15:0]                 mag_o
);

  localparam int CB = COORD_BITS;
  localparam int SH = ZQ - ANGLE_FRAC_BITS;
  localparam int MW = (CB > 16) ? CB : 16;
  localparam logic [ZW-1:0] HALF = ZW'(64'd1 << (SH - 1));
  localparam logic [ZW-1:0] CIRC = ZW'(64'd360 << ANGLE_FRAC_BITS);

  logic                 v1_r, v2_r;
  logic signed [ZW-1:0] zc, th, full_s;
  logic [ZW-1:0]        full_r, rsum, ang, ang_nxt;
  logic [CB-1:0]        mag1_r, mag1_nxt;
  logic [MW-1:0]        mag_ext;
  logic [15:0]          angle_r, mag_r;

  always_comb begin
    if (z_i[ZW-1]) begin
      zc = '0;
    end else if (z_i > DEG90_Q) begin
      zc = DEG90_Q;
    end else begin
      zc = z_i;
    end
    // axis vectors bypass the CORDIC residue
    if (flags_i.ay_zero) begin
      th = '0;
    end else if (flags_i.ax_zero) begin
      th = DEG90_Q;
    end else begin
      th = zc;
    end
    case ({flags_i.y_neg, flags_i.x_neg})
      2'b00:   full_s = th;
      2'b01:   full_s = DEG180_Q - th;
      2'b10:   full_s = DEG360_Q - th;
      2'b11:   full_s = DEG180_Q + th;
      default: full_s = th;
    endcase
  end

  // round to nearest: floor root plus one when the remainder exceeds it
  assign mag1_nxt = q_i + CB'(rem_i > {2'b00, q_i});

  assign rsum    = full_r + HALF;
  assign ang     = rsum >> SH;
  assign ang_nxt = (ang >= CIRC) ? ang - CIRC : ang;
  assign mag_ext = MW'(mag1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    full_r  <= $unsigned(full_s);
    mag1_r  <= mag1_nxt;
    angle_r <= ang_nxt[15:0];
    mag_r   <= mag_ext[15:0];
  end

  assign valid_o = v2_r;
  assign angle_o = angle_r;
  assign mag_o   = mag_r;

endmodule

`default_nettype wire

### src/vector_to_polar_top.sv
// Top level: pipelined CORDIC vector-to-polar converter with parallel square root.
`default_nettype none

// Converts a signed vector (x, y) to its angle (1/2^ANGLE_FRAC_BITS degree, 0 to
// just under 360) and rounded magnitude. A new vector is taken every clock cycle;
// busy is high only while reset is asserted. Each result passes through two input
// stages, NS rotation/root stages and two output stages, where NS is the larger of
// the 24 CORDIC micro-rotations and the COORD_BITS square-root digit stages.
// out_valid is high for one cycle per result and the receiver cannot hold
// results off.

module vector_to_polar_top
  import v2p_pkg::*;
#(
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] in_x_component,
  input  wire logic signed [COORD_BITS-1:0] in_y_component,
  output logic                              out_valid,
  output logic [15:0]                       out_angle_deg,
  output logic [15:0]                       out_magnitude
);

  localparam int CB   = COORD_BITS;
  localparam int NS   = (CORDIC_STEPS > CB) ? CORDIC_STEPS : CB;
  localparam int LAT  = NS + 4;
  localparam int S    = 60 - CB;
  localparam int CIRC_OUT = 360 * (2 ** ANGLE_FRAC_BITS);

  logic                 accept;
  logic                 f_valid;
  v2p_flags_t           f_flags;
  logic [CB-1:0]        f_ax, f_ay;
  logic [2*CB-1:0]      f_n;

  logic                 st_valid [0:NS];
  v2p_flags_t           st_flags [0:NS];
  logic signed [CW-1:0] st_cx    [0:NS];
  logic signed [CW-1:0] st_cy    [0:NS];
  logic signed [ZW-1:0] st_z     [0:NS];
  logic [2*CB-1:0]      st_n     [0:NS];
  logic [CB+1:0]        st_rem   [0:NS];
  logic [CB-1:0]        st_q     [0:NS];

  assign busy   = ~rst_n;
  assign accept = start && !busy;

  v2p_front #(
    .COORD_BITS(CB)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (accept),
    .x_i     (in_x_component),
    .y_i     (in_y_component),
    .valid_o (f_valid),
    .flags_o (f_flags),
    .ax_o    (f_ax),
    .ay_o    (f_ay),
    .n_o     (f_n)
  );

  assign st_valid[0] = f_valid;
  assign st_flags[0] = f_flags;
  assign st_cx[0]    = $signed(CW'(f_ax) << S);
  assign st_cy[0]    = $signed(CW'(f_ay) << S);
  assign st_z[0]     = '0;
  assign st_n[0]     = f_n;
  assign st_rem[0]   = '0;
  assign st_q[0]     = '0;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    v2p_cordic_step #(
      .STEP   (k),
      .ACTIVE (k < CORDIC_STEPS)
    ) u_cordic (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (st_valid[k]),
      .flags_i (st_flags[k]),
      .cx_i    (st_cx[k]),
      .cy_i    (st_cy[k]),
      .z_i     (st_z[k]),
      .valid_o (st_valid[k+1]),
      .flags_o (st_flags[k+1]),
      .cx_o    (st_cx[k+1]),
      .cy_o    (st_cy[k+1]),
      .z_o     (st_z[k+1])
    );

    v2p_sqrt_step #(
      .COORD_BITS (CB),
      .ACTIVE     (k < CB)
    ) u_sqrt (
      .clk   (clk),
      .n_i   (st_n[k]),
      .rem_i (st_rem[k]),
      .q_i   (st_q[k]),
      .n_o   (st_n[k+1]),
      .rem_o (st_rem[k+1]),
      .q_o   (st_q[k+1])
    );
  end

  v2p_back #(
    .COORD_BITS      (CB),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (st_valid[NS]),
    .flags_i (st_flags[NS]),
    .z_i     (st_z[NS]),
    .rem_i   (st_rem[NS]),
    .q_i     (st_q[NS]),
    .valid_o (out_valid),
    .angle_o (out_angle_deg),
    .mag_o   (out_magnitude)
  );

  // every accepted start beat yields a result strobe, and no strobe comes without one
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("start beat without result strobe at pipeline latency");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without matching start beat");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CIRC_OUT > 65536) || (32'(out_angle_deg) < CIRC_OUT))
    else $error("angle not wrapped below full circle");

  // only the zero vector has zero length, and it reports angle zero
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_magnitude == '0)) |-> (CB > 16) || (out_angle_deg == '0))
    else $error("zero magnitude with nonzero angle");

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for vector_to_polar_top: random and directed vectors against a polar predictor.
module tb_top;
  import v2p_pkg::*;

  localparam int COORD_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int ANG_SHIFT       = 24 - ANGLE_FRAC_BITS;
  localparam longint FULL_CIRCLE = longint'(360) << ANGLE_FRAC_BITS;
  localparam int RANDOM_VECTORS  = 1950;
  localparam int MAX_GAP         = 12;
  localparam int DRAIN_CYCLES    = 40;
  localparam int STALL_LIMIT     = 2000;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    int                           gap;
  } vec_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [15:0]                  angle;
    logic [15:0]                  mag;
  } polar_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic signed [COORD_BITS-1:0] in_x_component = '0;
  logic signed [COORD_BITS-1:0] in_y_component = '0;
  logic busy;
  logic out_valid;
  logic [15:0] out_angle_deg;
  logic [15:0] out_magnitude;

  vec_t   vec_pending[$];
  polar_t polar_expected[$];
  int     vec_total;
  int     beats_in = 0;
  int     beat_errors = 0;
  int     idle_left = 0;
  int     stall_cycles = 0;

  vector_to_polar_top #(
    .COORD_BITS      (COORD_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_x_component (in_x_component),
    .in_y_component (in_y_component),
    .out_valid      (out_valid),
    .out_angle_deg  (out_angle_deg),
    .out_magnitude  (out_magnitude)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // atan(2^-i) in 2^-24 degree
  function automatic longint micro_angle(int i);
    longint lo[12];
    lo = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
           15018523, 7509720, 3754917, 1877466, 938734, 469367};
    if (i < 12) return lo[i];
    return (longint'(961263669) + (longint'(1) << (i - 1))) >>> i;
  endfunction

  // first-quadrant angle of (ax, ay) in 2^-24 degree, vectoring mode
  function automatic longint quadrant_angle(longint ax, longint ay);
    longint cx, cy, z, nx;
    if (ay == 0) return 0;
    if (ax == 0) return longint'(90) << 24;
    cx = ax <<< (60 - COORD_BITS);
    cy = ay <<< (60 - COORD_BITS);
    z = 0;
    for (int i = 0; i < 24; i++) begin
      if (cy > 0) begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z += micro_angle(i);
      end else begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z -= micro_angle(i);
      end
      cx = nx;
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) << 24)) z = longint'(90) << 24;
    return z;
  endfunction

  function automatic longint unsigned rounded_root(longint unsigned n);
    longint unsigned rem, res, bitv;
    rem = n;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (rem > res) res++;
    return res;
  endfunction

  function automatic polar_t to_polar(logic signed [COORD_BITS-1:0] x,
                                      logic signed [COORD_BITS-1:0] y);
    longint sx, sy, ax, ay, th, full, ang;
    longint unsigned mag;
    polar_t r;
    sx = x;
    sy = y;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    r.x = x;
    r.y = y;
    if (sx == 0 && sy == 0) begin
      r.angle = '0;
      r.mag = '0;
      return r;
    end
    th = quadrant_angle(ax, ay);
    if (sy >= 0) full = (sx >= 0) ? th : (longint'(180) << 24) - th;
    else         full = (sx >= 0) ? (longint'(360) << 24) - th : (longint'(180) << 24) + th;
    ang = (full + (longint'(1) << (ANG_SHIFT - 1))) >>> ANG_SHIFT;
    if (ang >= FULL_CIRCLE) ang -= FULL_CIRCLE;
    mag = rounded_root(longint'(ax * ax) + longint'(ay * ay));
    r.angle = ang[15:0];
    r.mag = mag[15:0];
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord(int span);
    return COORD_BITS'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic add_vec(int x, int y, int gap);
    vec_t v;
    v.x = COORD_BITS'(x);
    v.y = COORD_BITS'(y);
    v.gap = gap;
    vec_pending.push_back(v);
  endtask

  // input driver: holds the beat while busy, then waits the next vector's gap
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left <= 0;
    end else begin
      if (start && !busy) begin
        polar_expected.push_back(to_polar(in_x_component, in_y_component));
        beats_in <= beats_in + 1;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (vec_pending.size() != 0) begin
        in_x_component <= vec_pending[0].x;
        in_y_component <= vec_pending[0].y;
        start <= 1'b1;
        void'(vec_pending.pop_front());
        idle_left <= (vec_pending.size() != 0) ? vec_pending[0].gap : 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    polar_t e;
    if (rst_n && out_valid === 1'b1) begin
      if (polar_expected.size() == 0) begin
        $display("%0t: unexpected result angle=%0d mag=%0d", $time, out_angle_deg,
                 out_magnitude);
        beat_errors++;
      end else begin
        e = polar_expected.pop_front();
        if (out_angle_deg !== e.angle) begin
          $display("%0t: angle mismatch for (%0d,%0d): expected %0d, actual %0d", $time,
                   e.x, e.y, e.angle, out_angle_deg);
          beat_errors++;
        end
        if (out_magnitude !== e.mag) begin
          $display("%0t: magnitude mismatch for (%0d,%0d): expected %0d, actual %0d", $time,
                   e.x, e.y, e.mag, out_magnitude);
          beat_errors++;
        end
      end
    end
  end

  // watchdog: cycles with neither an input nor a result beat
  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int  kind;
    bit  calm;
    int  gap;
    // zero vector, axes both ways, corners, diagonals
    add_vec(0, 0, 0);
    add_vec(1, 0, 0);
    add_vec(32767, 0, 3);
    add_vec(0, 1, 0);
    add_vec(0, 32767, 0);
    add_vec(-1, 0, 12);
    add_vec(-32768, 0, 0);
    add_vec(0, -1, 0);
    add_vec(0, -32768, 1);
    add_vec(32767, 32767, 0);
    add_vec(-32768, -32768, 0);
    add_vec(-32768, 32767, 0);
    add_vec(32767, -32768, 5);
    add_vec(1, 1, 0);
    add_vec(-1, 1, 0);
    add_vec(-1, -1, 0);
    add_vec(1, -1, 0);
    // just below the positive x axis: rounds up to a full circle and wraps
    add_vec(32767, -1, 0);
    add_vec(32767, 1, 2);
    add_vec(1, 32767, 0);
    add_vec(-32768, 1, 0);
    add_vec(-32768, -1, 0);
    add_vec(1, -32768, 0);

    calm = 1'b0;
    for (int k = 0; k < RANDOM_VECTORS; k++) begin
      if (k % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      kind = $urandom_range(0, 99);
      if (kind < 60)       add_vec(rand_coord(32768), rand_coord(32768), gap);
      else if (kind < 75)  add_vec(rand_coord(64), rand_coord(64), gap);
      else if (kind < 85) begin
        if ($urandom_range(0, 1)) add_vec(rand_coord(32768), 0, gap);
        else                      add_vec(0, rand_coord(32768), gap);
      end else if (kind < 95) begin
        // near the x axis, or anywhere in range
        if ($urandom_range(0, 1)) add_vec(rand_coord(32768), rand_coord(3), gap);
        else add_vec(rand_coord(32767), rand_coord(32767), gap);
      end else begin
        add_vec($urandom_range(0, 1) ? -32768 : 32767,
                $urandom_range(0, 1) ? -32768 : 32767, gap);
      end
    end
    vec_total = vec_pending.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_in < vec_total) @(posedge clk);
    while (polar_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (beat_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/v2p_pkg.sv
src/v2p_front.sv
src/v2p_cordic_step.sv
src/v2p_sqrt_step.sv
src/v2p_back.sv
src/vector_to_polar_top.sv
sim/tb_top.sv
